[hdl/pffma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffma_pkg: shared types and constants of the paged first-fit allocator
// Sequencer states, request modes and configuration register indexes.
// ----------------------------------------------------------------------------
package pffma_pkg;

  // Width of the configuration register index.
  localparam int CFG_ADDR_BITS = 2;

  localparam logic [CFG_ADDR_BITS-1:0] REG_VERTEX_DEFAULT = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_INDEX_DEFAULT  = CFG_ADDR_BITS'(1);

  // Allocation request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TEST,
    S_CHECK,
    S_WRV,
    S_WRI,
    S_DONE
  } state_t;

endpackage

[hdl/pffma_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffma_in_if: request channel
// Valid/ready channel carrying one allocate or clear request per beat.
// ----------------------------------------------------------------------------
interface pffma_in_if #(
  parameter int COUNT_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [COUNT_BITS-1:0] vtx_count;
  logic [COUNT_BITS-1:0] ind_count;

  modport source(output valid, mode, vtx_count, ind_count, input ready);
  modport sink(input valid, mode, vtx_count, ind_count, output ready);
endinterface

[hdl/pffma_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffma_out_if: result channel
// Valid/ready channel carrying one placement result per beat.
// ----------------------------------------------------------------------------
interface pffma_out_if #(
  parameter int COUNT_BITS = 24,
  parameter int PAGE_BITS  = 4
) ();
  logic                  valid;
  logic                  ready;
  logic [PAGE_BITS-1:0]  vtx_page;
  logic [COUNT_BITS-1:0] vtx_offset;
  logic                  vertex_opened;
  logic [PAGE_BITS-1:0]  ind_page;
  logic [COUNT_BITS-1:0] ind_offset;
  logic                  index_opened;
  logic [1:0]            status;

  modport source(output valid, vtx_page, vtx_offset, vertex_opened, ind_page,
                 ind_offset, index_opened, status, input ready);
  modport sink(input valid, vtx_page, vtx_offset, vertex_opened, ind_page,
               ind_offset, index_opened, status, output ready);
endinterface

[hdl/pffma_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffma_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface pffma_cfg_if
  import pffma_pkg::*;
#(
  parameter int COUNT_BITS = 24
) ();
  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] index;
  logic [COUNT_BITS-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hdl/paged_first_fit_mesh_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_first_fit_mesh_allocator: first-fit page allocator for mesh buffers
// Places vertex and index ranges into bump-filled pages, opening new pages.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_ch, one per beat. An allocate beat (mode 0) asks for
// a vertex count and an index count; a clear beat (mode 1) empties both page
// tables. Each request gives exactly one result beat on out_ch.
// The user must write page default sizes through cfg_ch only while the block is
// idle (the block does not enforce it); index 0 is the vertex default, 1 the index default.
// Sequencing: each table is scanned one page at a time through a registered
// RAM read and one shared compare unit; each page tested passes a read state
// (S_SCAN) and a test state (S_TEST). After both scans come a decision state
// (S_CHECK), one write state per table (S_WRV, S_WRI) and a state that loads
// the result register (S_DONE); a table-full reject skips the write states.
// A clear goes from its beat straight to the result-loading state. Only one
// request is in flight, so in_ch is ready only while the sequencer idles.
// Reset clears both open-page counts and restores the default sizes; page
// contents are never cleared since only pages below the open count are read.
// If out_ch stalls, the result waits in the output register; the next request
// may be accepted and worked on, and it holds in its final state until the
// output register is free.
// ----------------------------------------------------------------------------
module paged_first_fit_mesh_allocator
  import pffma_pkg::*;
#(
  parameter int MAX_PAGES  = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  pffma_in_if.sink          in_ch,
  pffma_out_if.source       out_ch,
  pffma_cfg_if.sink         cfg_ch
);
  localparam int PAGE_BITS = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  // Open counts must hold MAX_PAGES itself.
  localparam int OPEN_BITS = $clog2(MAX_PAGES + 1);
  localparam int WORD_BITS = 2 * COUNT_BITS;
  localparam logic [OPEN_BITS-1:0] FULL_COUNT = OPEN_BITS'(MAX_PAGES);

  // Outcome of scanning one table. For a newly opened page fill is zero,
  // which is also the offset returned.
  typedef struct packed {
    logic [PAGE_BITS-1:0]  page;
    logic [COUNT_BITS-1:0] size;
    logic [COUNT_BITS-1:0] fill;
    logic                  opened;
    logic                  full;
  } pick_t;

  state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0] vdef_r, idef_r;
  logic [COUNT_BITS-1:0] vc_r, ic_r;
  logic [OPEN_BITS-1:0]  v_open_r, i_open_r;
  logic [OPEN_BITS-1:0]  idx_r;
  logic                  tab_r;     // 0 scans the vertex table, 1 the index table
  logic                  clear_r;
  pick_t                 v_pick_r, i_pick_r;

  logic                  out_valid_r;
  logic [PAGE_BITS-1:0]  o_vpage_r, o_ipage_r;
  logic [COUNT_BITS-1:0] o_voff_r, o_ioff_r;
  logic                  o_vopen_r, o_iopen_r;
  logic [1:0]            o_status_r;

  logic in_fire, out_fire, load_out;

  // RAM ports: each word is {size, fill}.
  logic [WORD_BITS-1:0] v_rdata, i_rdata, cur_rdata, wdata;
  logic [PAGE_BITS-1:0] raddr, waddr;
  logic                 v_we, i_we;

  // Shared compare unit operands.
  logic [COUNT_BITS-1:0] u_size, u_fill, u_count, u_sum;
  logic                  u_fits;

  logic [OPEN_BITS-1:0]  cur_open;
  logic [COUNT_BITS-1:0] cur_count;
  logic                  scan_end;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;
  assign load_out    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign cfg_ch.ready = 1'b1;

  assign cur_open  = tab_r ? i_open_r : v_open_r;
  assign cur_count = tab_r ? ic_r : vc_r;
  assign cur_rdata = tab_r ? i_rdata : v_rdata;
  assign scan_end  = (idx_r == cur_open);
  assign raddr     = idx_r[PAGE_BITS-1:0];

  pffma_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_PAGES)) u_vtab (
    .clk   (clk),
    .we    (v_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (v_rdata)
  );

  pffma_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_PAGES)) u_itab (
    .clk   (clk),
    .we    (i_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (i_rdata)
  );

  pffma_fit_unit #(.COUNT_BITS(COUNT_BITS)) u_fit (
    .size  (u_size),
    .fill  (u_fill),
    .count (u_count),
    .fits  (u_fits),
    .sum   (u_sum)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.mode == MODE_CLEAR) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = tab_r ? S_CHECK : S_SCAN;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (u_fits && tab_r) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_CHECK: begin
        state_nxt = (v_pick_r.full || i_pick_r.full) ? S_DONE : S_WRV;
      end
      S_WRV:  state_nxt = S_WRI;
      S_WRI:  state_nxt = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control: operand selection for the shared unit and RAM writes.
  // When a page opens, the unit compares default >= count to size the page.
  always_comb begin
    u_size  = cur_rdata[WORD_BITS-1:COUNT_BITS];
    u_fill  = cur_rdata[COUNT_BITS-1:0];
    u_count = cur_count;
    v_we    = 1'b0;
    i_we    = 1'b0;
    waddr   = v_pick_r.page;
    wdata   = '0;
    unique case (state_r)
      S_WRV: begin
        u_count = vc_r;
        waddr   = v_pick_r.page;
        v_we    = 1'b1;
        if (v_pick_r.opened) begin
          u_size = vdef_r;
          u_fill = '0;
          wdata  = {(u_fits ? vdef_r : vc_r), vc_r};
        end else begin
          u_size = v_pick_r.size;
          u_fill = v_pick_r.fill;
          wdata  = {v_pick_r.size, u_sum};
        end
      end
      S_WRI: begin
        u_count = ic_r;
        waddr   = i_pick_r.page;
        i_we    = 1'b1;
        if (i_pick_r.opened) begin
          u_size = idef_r;
          u_fill = '0;
          wdata  = {(u_fits ? idef_r : ic_r), ic_r};
        end else begin
          u_size = i_pick_r.size;
          u_fill = i_pick_r.fill;
          wdata  = {i_pick_r.size, u_sum};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vdef_r      <= COUNT_BITS'(65536);
      idef_r      <= COUNT_BITS'(196608);
      v_open_r    <= '0;
      i_open_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_VERTEX_DEFAULT: vdef_r <= cfg_ch.data;
          REG_INDEX_DEFAULT:  idef_r <= cfg_ch.data;
          default: begin
          end
        endcase
      end

      if (in_fire && (in_ch.mode == MODE_CLEAR)) begin
        v_open_r <= '0;
        i_open_r <= '0;
      end
      if ((state_r == S_WRV) && v_pick_r.opened) begin
        v_open_r <= v_open_r + OPEN_BITS'(1);
      end
      if ((state_r == S_WRI) && i_pick_r.opened) begin
        i_open_r <= i_open_r + OPEN_BITS'(1);
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture, scan bookkeeping and result register (no reset needed).
  always_ff @(posedge clk) begin
    if (in_fire) begin
      vc_r    <= in_ch.vtx_count;
      ic_r    <= in_ch.ind_count;
      clear_r <= (in_ch.mode == MODE_CLEAR);
      tab_r   <= 1'b0;
      idx_r   <= '0;
    end

    if (state_r == S_SCAN && scan_end) begin
      // No open page fits: open the next one, or report the table full.
      if (tab_r) begin
        i_pick_r.page   <= cur_open[PAGE_BITS-1:0];
        i_pick_r.size   <= '0;
        i_pick_r.fill   <= '0;
        i_pick_r.opened <= (cur_open != FULL_COUNT);
        i_pick_r.full   <= (cur_open == FULL_COUNT);
      end else begin
        v_pick_r.page   <= cur_open[PAGE_BITS-1:0];
        v_pick_r.size   <= '0;
        v_pick_r.fill   <= '0;
        v_pick_r.opened <= (cur_open != FULL_COUNT);
        v_pick_r.full   <= (cur_open == FULL_COUNT);
        tab_r <= 1'b1;
        idx_r <= '0;
      end
    end

    if (state_r == S_TEST) begin
      if (u_fits) begin
        if (tab_r) begin
          i_pick_r.page   <= idx_r[PAGE_BITS-1:0];
          i_pick_r.size   <= u_size;
          i_pick_r.fill   <= u_fill;
          i_pick_r.opened <= 1'b0;
          i_pick_r.full   <= 1'b0;
        end else begin
          v_pick_r.page   <= idx_r[PAGE_BITS-1:0];
          v_pick_r.size   <= u_size;
          v_pick_r.fill   <= u_fill;
          v_pick_r.opened <= 1'b0;
          v_pick_r.full   <= 1'b0;
          tab_r <= 1'b1;
          idx_r <= '0;
        end
      end else begin
        idx_r <= idx_r + OPEN_BITS'(1);
      end
    end

    if (load_out) begin
      if (clear_r || v_pick_r.full || i_pick_r.full) begin
        // Clear and table-full results carry nothing but the status.
        o_vpage_r  <= '0;
        o_voff_r   <= '0;
        o_vopen_r  <= 1'b0;
        o_ipage_r  <= '0;
        o_ioff_r   <= '0;
        o_iopen_r  <= 1'b0;
        o_status_r <= clear_r ? 2'b00 : {i_pick_r.full, v_pick_r.full};
      end else begin
        o_vpage_r  <= v_pick_r.page;
        o_voff_r   <= v_pick_r.fill;
        o_vopen_r  <= v_pick_r.opened;
        o_ipage_r  <= i_pick_r.page;
        o_ioff_r   <= i_pick_r.fill;
        o_iopen_r  <= i_pick_r.opened;
        o_status_r <= 2'b00;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.vtx_page      = o_vpage_r;
  assign out_ch.vtx_offset    = o_voff_r;
  assign out_ch.vertex_opened = o_vopen_r;
  assign out_ch.ind_page      = o_ipage_r;
  assign out_ch.ind_offset    = o_ioff_r;
  assign out_ch.index_opened  = o_iopen_r;
  assign out_ch.status        = o_status_r;

endmodule

[hdl/pffma_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffma_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pffma_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/pffma_fit_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffma_fit_unit: shared room compare and bump adder
// Tells whether count fits in size minus fill and gives fill plus count.
// ----------------------------------------------------------------------------
module pffma_fit_unit #(
  parameter int COUNT_BITS = 24
) (
  input  logic [COUNT_BITS-1:0] size,
  input  logic [COUNT_BITS-1:0] fill,
  input  logic [COUNT_BITS-1:0] count,
  output logic                  fits,
  output logic [COUNT_BITS-1:0] sum
);
  logic [COUNT_BITS-1:0] room;

  // Fill never exceeds size, so the difference does not wrap.
  assign room = size - fill;
  assign fits = (room >= count);
  assign sum  = fill + count;
endmodule
